### rtl/core/cscan_pkg.sv
// shared types and constants for the c-scan disk request scheduler
package cscan_pkg;

	localparam int TRACK_BITS = 16;
	localparam int TAG_BITS   = 4;

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [TRACK_BITS-1:0] track;
		logic [TAG_BITS-1:0]   requester;
	} req_t;

	typedef struct packed {
		logic                  grant_valid;
		logic [TAG_BITS-1:0]   grant_requester;
		logic [TRACK_BITS-1:0] grant_track;
		logic                  disk_busy;
		logic                  dropped;
	} rsp_t;

	typedef struct packed {
		logic                  valid;
		logic                  sweep;
		logic [TAG_BITS-1:0]   tag;
		logic [TRACK_BITS-1:0] track;
	} entry_t;

	// broadcast from the controller to every cell of the chain
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   sweep_sel;
		logic   new_rel;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

### rtl/core/cscan_cell.sv
// one slot of the sorted wait chain
module cscan_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cscan_pkg::cell_ctrl_t ctrl,
	input  cscan_pkg::entry_t    below_entry,
	input  logic                 below_ins,
	input  cscan_pkg::entry_t    above_entry,
	output cscan_pkg::entry_t    entry,
	output logic                 ins
);

	cscan_pkg::entry_t slot_q;
	logic              own_rel;

	// key is (next sweep flag, track); ties keep arrival order
	always_comb begin
		own_rel = slot_q.sweep ^ ctrl.sweep_sel;
		ins = !slot_q.valid ||
			({ctrl.new_rel, ctrl.new_entry.track} < {own_rel, slot_q.track});
	end

	assign entry = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.valid <= 1'b0;
		end else if (ctrl.push) begin
			if (below_ins) begin
				slot_q <= below_entry;
			end else if (ins) begin
				slot_q <= ctrl.new_entry;
			end
		end else if (ctrl.pop) begin
			slot_q <= above_entry;
		end
	end

endmodule

### rtl/core/cscan_disk_request_scheduler.sv
// top level of the c-scan disk request scheduler
//
// one-way elevator arbiter for a disk head. each transfer on the req channel
// is a request (mode 0, with track and requester tag) or a release (mode 1),
// and produces exactly one transfer on the rsp channel carrying the grant,
// the busy flag after the item and a drop flag for a request lost to a full
// store.
// waiting requests live in a chain of QUEUE_DEPTH cells kept sorted by
// (sweep, track), so the best candidate always sits in cell 0. a request is
// inserted in parallel: every cell compares the new key with its own and
// the cells at and above the insertion point hand their entry upward. a
// release pops cell 0 and every cell takes its upper neighbor's entry.
// latency: the result appears in the cycle after the req transfer.
// one item is in flight at a time and req_stall stays high while a result
// sits in the rsp register.
// a stalled result holds on rsp until rsp_stall drops.
// reset empties the chain, clears the head to track 0, selects sweep 0 and
// leaves the disk idle; no clearing pass is needed.
module cscan_disk_request_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cscan_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cscan_pkg::rsp_t rsp
);

	// scheduler state
	logic                             held_q;
	logic [cscan_pkg::TRACK_BITS-1:0] head_q;
	logic                             sweep_sel_q;

	// result register
	logic            rsp_valid_q;
	cscan_pkg::rsp_t rsp_q;

	// chain wiring
	cscan_pkg::entry_t    chain_entry [QUEUE_DEPTH];
	logic                 chain_ins   [QUEUE_DEPTH];
	cscan_pkg::cell_ctrl_t ctrl;
	cscan_pkg::entry_t    empty_entry;

	logic            accept;
	logic            full;
	cscan_pkg::entry_t best;
	cscan_pkg::rsp_t rsp_next;

	assign req_stall = rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full = chain_entry[QUEUE_DEPTH-1].valid;
	assign best = chain_entry[0];

	always_comb begin
		empty_entry = '0;

		// new entry is tagged for the next sweep when it lies below the head
		ctrl.new_rel            = req.track < head_q;
		ctrl.sweep_sel          = sweep_sel_q;
		ctrl.new_entry.valid    = 1'b1;
		ctrl.new_entry.sweep    = sweep_sel_q ^ ctrl.new_rel;
		ctrl.new_entry.tag      = req.requester;
		ctrl.new_entry.track    = req.track;
		ctrl.push = accept && (req.mode == cscan_pkg::MODE_REQUEST) && held_q && !full;
		ctrl.pop  = accept && (req.mode == cscan_pkg::MODE_RELEASE) && held_q &&
			best.valid;

		rsp_next = '0;
		if (req.mode == cscan_pkg::MODE_REQUEST) begin
			if (!held_q) begin
				// idle disk: grant at once
				rsp_next.grant_valid     = 1'b1;
				rsp_next.grant_requester = req.requester;
				rsp_next.grant_track     = req.track;
				rsp_next.disk_busy       = 1'b1;
			end else begin
				rsp_next.disk_busy = 1'b1;
				rsp_next.dropped   = full;
			end
		end else if (held_q) begin
			if (best.valid) begin
				rsp_next.grant_valid     = 1'b1;
				rsp_next.grant_requester = best.tag;
				rsp_next.grant_track     = best.track;
				rsp_next.disk_busy       = 1'b1;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			cscan_pkg::entry_t below_e;
			cscan_pkg::entry_t above_e;
			logic              below_i;

			if (gi == 0) begin : g_first
				assign below_e = empty_entry;
				assign below_i = 1'b0;
			end else begin : g_mid
				assign below_e = chain_entry[gi-1];
				assign below_i = chain_ins[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign above_e = empty_entry;
			end else begin : g_inner
				assign above_e = chain_entry[gi+1];
			end

			cscan_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.below_entry (below_e),
				.below_ins   (below_i),
				.above_entry (above_e),
				.entry       (chain_entry[gi]),
				.ins         (chain_ins[gi])
			);
		end
	endgenerate

	// head, sweep and busy state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			head_q      <= '0;
			sweep_sel_q <= 1'b0;
		end else if (accept) begin
			if (req.mode == cscan_pkg::MODE_REQUEST) begin
				if (!held_q) begin
					held_q <= 1'b1;
					head_q <= req.track;
				end
			end else if (held_q) begin
				if (best.valid) begin
					head_q <= best.track;
					// cell 0 outside the current sweep means the current one is empty
					if (best.sweep != sweep_sel_q) begin
						sweep_sel_q <= ~sweep_sel_q;
					end
				end else begin
					held_q <= 1'b0;
					// both sweeps empty: the swap toggles the select before idling
					sweep_sel_q <= ~sweep_sel_q;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

endmodule
